// ----- rtl/mroe_pkg.sv -----
// ----------------------------------------------------------------------------
// mroe_pkg
// Types and constants shared by the matrix row operation engine files.
// ----------------------------------------------------------------------------
package mroe_pkg;

  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int NUM_W  = DATA_W + FRAC_W + 1;
  localparam int WIDE_W = 50;

  localparam logic [3:0] ROWS_RST = 4'd8;
  localparam logic [3:0] COLS_RST = 4'd8;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_READ   = 3'd1,
    CMD_SWAP   = 3'd2,
    CMD_MUL    = 3'd3,
    CMD_DIV    = 3'd4,
    CMD_SUBMUL = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WAIT,
    S_ARITH,
    S_DIV,
    S_WR2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
    mag32 = x[DATA_W-1] ? DATA_W'(~x + 1'b1) : x;
  endfunction

endpackage

// ----- rtl/mroe_if.sv -----
// ----------------------------------------------------------------------------
// mroe_in_if / mroe_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface mroe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [2:0]  dest_row;
  logic [2:0]  source_row;
  logic [2:0]  column;
  logic signed [31:0] operand_value;

  modport source (output valid, command, dest_row, source_row, column, operand_value,
                  input ready);
  modport sink   (input valid, command, dest_row, source_row, column, operand_value,
                  output ready);
endinterface

interface mroe_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] read_value;
  logic [1:0]  status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

// ----- rtl/matrix_row_operation_engine_unit.sv -----
// ----------------------------------------------------------------------------
// matrix_row_operation_engine_unit
// Elementary row operations on a Q15.16 matrix held in a block memory.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  in_ch   | in  | valid/ready     | command, dest_row, source_row, column, operand_value
//  out_ch  | out | valid/ready     | read_value, status
//  apb     | in  | psel/penable    | paddr, pwrite, pwdata, prdata, pready
//
//  Write, error and empty row beats go straight to done; a read passes read and
//  wait. Swap, multiply and subtract pass read, wait and a write state per
//  column in use; divide read, wait and the one-bit-a-cycle divider. One
//  command at a time; the next beat is taken while the output register is full.
//  Synchronous active-low reset clears control state; the matrix is not reset.
// ----------------------------------------------------------------------------
module matrix_row_operation_engine_unit
  import mroe_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mroe_in_if.sink     in_ch,
  mroe_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NCW   = $clog2(MAX_COLS + 1);

  logic [3:0] rows_r, cols_r;

  state_t state_r, state_nxt;
  logic [2:0]  cmd_r, dr_r, sr_r;
  logic [NCW-1:0] ci_r, nc_r;
  logic [DATA_W-1:0] val_r;
  logic sat_r, neg_r;
  logic [63:0] prod_r;
  status_t status_r;
  logic [DATA_W-1:0] rdval_r;
  logic out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  status_t out_status_r;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] q_a, q_b;
  logic rd_en, we;
  logic [AW-1:0] addr_a, addr_b, waddr;
  logic [DATA_W-1:0] wdata;

  div_ctl_t div_in, div_out;
  logic [NUM_W-1:0] div_num, quo;

  logic accept;
  logic bad;
  int nr_i, nc_i;
  logic [DATA_W-1:0] mag_v, mag_x;
  logic [47:0] m48;
  logic [WIDE_W-1:0] sv, res;
  logic res_sat;
  logic [DATA_W-1:0] res32;
  logic last_col;

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RST;
      cols_r <= COLS_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_ROWS) rows_r <= pwdata[3:0];
      else cols_r <= pwdata[3:0];
    end
  end
  assign prdata = (paddr[2] == REG_ROWS) ? {28'd0, rows_r} : {28'd0, cols_r};

  // acceptance and range checks
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    nr_i = (int'(rows_r) < MAX_ROWS) ? int'(rows_r) : MAX_ROWS;
    nc_i = (int'(cols_r) < MAX_COLS) ? int'(cols_r) : MAX_COLS;
    bad  = (in_ch.command > CMD_SUBMUL) || (int'(in_ch.dest_row) >= nr_i) ||
           ((in_ch.command == CMD_SWAP || in_ch.command == CMD_SUBMUL) &&
            int'(in_ch.source_row) >= nr_i) ||
           ((in_ch.command == CMD_WRITE || in_ch.command == CMD_READ) &&
            int'(in_ch.column) >= nc_i);
  end

  // memory
  assign addr_a = AW'(int'(dr_r) * MAX_COLS + int'(ci_r));
  assign addr_b = AW'(int'(sr_r) * MAX_COLS + int'(ci_r));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a <= mem[addr_a];
      q_b <= mem[addr_b];
    end
  end

  // arithmetic
  assign mag_v = mag32(val_r);
  assign mag_x = (cmd_r == CMD_MUL) ? mag32(q_a) : mag32(q_b);
  assign m48   = 48'((prod_r + 64'h8000) >> FRAC_W);
  assign div_num = NUM_W'({mag32(q_a), 16'h0}) + NUM_W'(mag_v[DATA_W-1:1]);

  always_comb begin
    if (state_r == S_DIV) sv = neg_r ? WIDE_W'(-{1'b0, quo}) : WIDE_W'({1'b0, quo});
    else sv = neg_r ? WIDE_W'(-{2'b0, m48}) : WIDE_W'({2'b0, m48});
    if (cmd_r == CMD_SUBMUL) res = {{(WIDE_W-DATA_W){q_a[DATA_W-1]}}, q_a} - sv;
    else res = sv;
    res_sat = (res[WIDE_W-1:DATA_W-1] != '0) && (res[WIDE_W-1:DATA_W-1] != '1);
    if (res_sat) res32 = res[WIDE_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    else res32 = res[DATA_W-1:0];
  end

  mroe_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (div_in),
    .ctl_out (div_out),
    .num     (div_num),
    .den     (mag_v),
    .quo     (quo)
  );

  assign last_col = (ci_r + 1'b1 == nc_r);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    rd_en        = 1'b0;
    we           = 1'b0;
    waddr        = addr_a;
    wdata        = res32;
    div_in.start = 1'b0;
    div_in.done  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (bad) state_nxt = S_DONE;
          else if (in_ch.command == CMD_WRITE) begin
            we        = 1'b1;
            waddr     = AW'(int'(in_ch.dest_row) * MAX_COLS + int'(in_ch.column));
            wdata     = in_ch.operand_value;
            state_nxt = S_DONE;
          end else if (in_ch.command == CMD_READ) state_nxt = S_RD;
          else if (in_ch.command == CMD_DIV && in_ch.operand_value == '0) state_nxt = S_DONE;
          else if (nc_i == 0) state_nxt = S_DONE;
          else state_nxt = S_RD;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        case (cmd_r)
          CMD_READ: state_nxt = S_DONE;
          CMD_SWAP: begin
            we        = 1'b1;
            wdata     = q_b;
            state_nxt = S_WR2;
          end
          CMD_DIV: begin
            div_in.start = 1'b1;
            state_nxt    = S_DIV;
          end
          default: state_nxt = S_ARITH;
        endcase
      end
      S_WR2: begin
        we        = 1'b1;
        waddr     = addr_b;
        wdata     = q_a;
        state_nxt = last_col ? S_DONE : S_RD;
      end
      S_ARITH: begin
        we        = 1'b1;
        state_nxt = last_col ? S_DONE : S_RD;
      end
      S_DIV: begin
        if (div_out.done) begin
          we        = 1'b1;
          state_nxt = last_col ? S_DONE : S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_ch.command;
      dr_r    <= in_ch.dest_row;
      sr_r    <= in_ch.source_row;
      val_r   <= in_ch.operand_value;
      nc_r    <= NCW'(nc_i);
      sat_r   <= 1'b0;
      rdval_r <= '0;
      ci_r    <= (in_ch.command == CMD_READ) ? NCW'(in_ch.column) : '0;
      if (bad) status_r <= ST_RANGE;
      else if (in_ch.command == CMD_DIV && in_ch.operand_value == '0) status_r <= ST_DIVZERO;
      else status_r <= ST_OK;
    end
    if (state_r == S_WAIT) begin
      if (cmd_r == CMD_READ) rdval_r <= q_a;
      prod_r <= 64'(mag_x) * 64'(mag_v);
      neg_r  <= ((cmd_r == CMD_MUL || cmd_r == CMD_DIV) ? q_a[DATA_W-1] : q_b[DATA_W-1]) ^
                val_r[DATA_W-1];
    end
    if (we && (state_r == S_ARITH || state_r == S_DIV) && res_sat) sat_r <= 1'b1;
    if (state_r == S_WR2 || state_r == S_ARITH || (state_r == S_DIV && div_out.done))
      ci_r <= ci_r + 1'b1;
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_data_r   <= rdval_r;
      out_status_r <= (status_r == ST_OK && sat_r) ? ST_SAT : status_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_data_r;
  assign out_ch.status     = out_status_r;

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> out_valid_r) else $error("result not loaded");
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD && cmd_r != CMD_READ) |-> (ci_r < nc_r)) else $error("column overrun");
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_out.done |-> (state_r == S_DIV)) else $error("stray divider done");
  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (we && state_r == S_IDLE) |-> (accept && in_ch.command == CMD_WRITE))
    else $error("stray memory write");

endmodule

// ----- rtl/mroe_div.sv -----
// ----------------------------------------------------------------------------
// mroe_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mroe_div
  import mroe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctl_t          ctl_in,
  output div_ctl_t          ctl_out,
  input  logic [NUM_W-1:0]  num,
  input  logic [DATA_W-1:0] den,
  output logic [NUM_W-1:0]  quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_r;
  logic [DATA_W-1:0] den_r;
  logic [DATA_W:0]   rem_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W:0]   rem_sh;
  logic              qbit;

  assign rem_sh = {rem_r[DATA_W-1:0], num_r[NUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl_in.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
      num_r <= {num_r[NUM_W-2:0], qbit};
    end
  end

  assign quo           = num_r;
  assign ctl_out.start = 1'b0;
  assign ctl_out.done  = done_r;

endmodule
